// File: hdl/run_length_byte_decoder_top_defines.svh
// Assertion macros used by the run-length byte decoder run queue.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef RUN_LENGTH_BYTE_DECODER_TOP_DEFINES_SVH
`define RUN_LENGTH_BYTE_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/rlbd_pkg.sv
// Shared types and constants of the run-length byte decoder.
// No dependencies.
`default_nettype none

package rlbd_pkg;

  localparam int PixelCountBitsDef = 24;
  localparam int ValueW            = 8;
  localparam int LenW              = 25;
  localparam int QueueDepth        = 4;
  localparam int QPtrW             = $clog2(QueueDepth);
  localparam int QCntW             = $clog2(QueueDepth + 1);

  localparam logic [LenW-1:0]   PixelTotalReset = 25'd65536;
  localparam logic [LenW-1:0]   CountMax        = '1;
  localparam logic [ValueW-1:0] ByteEsc         = 8'hFF;

  // One run descriptor
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
    logic              last;
  } run_t;

  // Runs produced by one input byte, in order (first, then second)
  typedef struct packed {
    logic [1:0] count;
    run_t       first;
    run_t       second;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/rlbd_front.sv
// Front end: parses the code byte stream and turns it into clipped run descriptors.
// Depends on rlbd_pkg.
`default_nettype none

module rlbd_front
  import rlbd_pkg::*;
#(
  parameter int PixelCountBits = PixelCountBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [LenW-1:0]   cfg_wdata,
  input  wire logic              take,
  input  wire logic [ValueW-1:0] code_byte,
  input  wire logic              stream_last,
  output push_t                  push
);

  localparam int CntW = (PixelCountBits + 1 > LenW + 1) ? PixelCountBits + 1 : LenW + 1;
  localparam logic [CntW-1:0] Cap = CntW'(64'd1 << PixelCountBits);

  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_EMPTY = 2'd1;
  localparam logic [1:0] PH_HELD  = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  logic [CntW-1:0]   budget;
  logic [CntW-1:0]   budget_raw;
  logic [CntW-1:0]   budget_next;
  logic [1:0]        phase, phase_next;
  logic [ValueW-1:0] held, held_next;
  logic [LenW-1:0]   count_accum, count_next;
  logic [CntW-1:0]   pixels_done, pixels_done_next;

  logic              full;
  logic [CntW-1:0]   left;
  logic [LenW:0]     sum;
  logic [LenW-1:0]   sum_sat;
  logic              is_esc;
  logic              is_eq;
  logic [LenW:0]     want;
  logic [CntW-1:0]   want_x;
  logic              a_short;
  logic [CntW-1:0]   len_a;
  logic [CntW-1:0]   pad_len;
  logic              a_fire;
  logic              pad_fire;
  run_t              run_a;
  run_t              run_p;

  // Budget register, clamped to 1 .. 2^PixelCountBits when loaded
  assign budget_raw = rst ? {{(CntW-LenW){1'b0}}, PixelTotalReset}
                          : {{(CntW-LenW){1'b0}}, cfg_wdata};

  always_comb begin
    if (budget_raw == '0) begin
      budget_next = CntW'(1);
    end else if (budget_raw > Cap) begin
      budget_next = Cap;
    end else begin
      budget_next = budget_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      budget <= budget_next;
    end
  end

  // Classification
  assign full    = pixels_done >= budget;
  assign left    = budget - pixels_done;
  assign is_esc  = code_byte == ByteEsc;
  assign is_eq   = code_byte == held;
  assign sum     = {1'b0, count_accum} + {{(LenW+1-ValueW){1'b0}}, code_byte};
  assign sum_sat = sum[LenW] ? CountMax : sum[LenW-1:0];

  always_comb begin
    unique case (phase)
      PH_HELD:  want = is_eq ? (LenW+1)'(2) : (LenW+1)'(1);
      default:  want = {1'b0, sum_sat} + (LenW+1)'(2);
    endcase
  end

  // A data run fires on a value change, at the end of a count chain, or when
  // the stream stops inside a pending run.
  assign a_fire = take && !full &&
                  (((phase == PH_HELD) && (!is_eq || stream_last)) ||
                   ((phase == PH_COUNT) && (!is_esc || stream_last)));

  // Clip to the pixels left in the image
  assign want_x  = CntW'(want);
  assign a_short = want_x < left;
  assign len_a   = a_short ? want_x : left;

  // Zero pad fills whatever remains at end of stream
  assign pad_fire = take && stream_last && (a_fire ? a_short : !full);
  assign pad_len  = a_fire ? left - len_a : left;

  assign run_a = '{value: held, length: len_a[LenW-1:0], last: !a_short};
  assign run_p = '{value: '0, length: pad_len[LenW-1:0], last: 1'b1};

  assign push.count  = {1'b0, a_fire} + {1'b0, pad_fire};
  assign push.first  = a_fire ? run_a : run_p;
  assign push.second = run_p;

  // Parser state update
  always_comb begin
    phase_next       = phase;
    held_next        = held;
    count_next       = count_accum;
    pixels_done_next = pixels_done;
    if (take) begin
      if (stream_last) begin
        phase_next       = PH_SKIP;
        held_next        = '0;
        count_next       = '0;
        pixels_done_next = '0;
      end else if (!full) begin
        unique case (phase)
          PH_SKIP: begin
            phase_next = PH_EMPTY;
          end
          PH_EMPTY: begin
            held_next  = code_byte;
            phase_next = PH_HELD;
          end
          PH_HELD: begin
            if (is_eq) begin
              count_next = '0;
              phase_next = PH_COUNT;
            end else begin
              held_next        = code_byte;
              pixels_done_next = pixels_done + len_a;
            end
          end
          PH_COUNT: begin
            if (is_esc) begin
              count_next = sum_sat;
            end else begin
              count_next       = '0;
              phase_next       = PH_EMPTY;
              pixels_done_next = pixels_done + len_a;
            end
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      held        <= '0;
      count_accum <= '0;
      pixels_done <= '0;
    end else begin
      phase       <= phase_next;
      held        <= held_next;
      count_accum <= count_next;
      pixels_done <= pixels_done_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rlbd_queue.sv
// Run descriptor queue between parser and output stage: up to two writes, one read a cycle.
// Depends on rlbd_pkg and the assertion macro header.
`default_nettype none
`include "run_length_byte_decoder_top_defines.svh"

module rlbd_queue
  import rlbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       rd_valid,
  output run_t       rd_data,
  input  wire logic  pop
);

  run_t             mem [QueueDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] cnt;

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr + QPtrW'(1)] <= push.second;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + QPtrW'(push.count);
      rptr <= rptr + QPtrW'(pop);
      cnt  <= cnt + QCntW'(push.count) - QCntW'(pop);
    end
  end

  assign room     = cnt <= QCntW'(QueueDepth - 2);
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rptr];

  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt <= QCntW'(QueueDepth))
  `ASSERT_IMPLY(a_push_room, clk, rst, push.count != 2'd0, room)
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst, pop, cnt != '0)
  `ASSERT_NEXT(a_double_push, clk, rst, (push.count == 2'd2) && !pop, cnt == $past(cnt) + QCntW'(2))

endmodule

`default_nettype wire

// File: hdl/rlbd_back.sv
// Back end: output register that drains the run queue onto the result stream.
// Depends on rlbd_pkg.
`default_nettype none

module rlbd_back
  import rlbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rd_valid,
  input  wire run_t rd_data,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output run_t      out_run
);

  // Load a new run whenever the register is empty or being taken
  assign pop = rd_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_run <= rd_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/run_length_byte_decoder_top.sv
// Top level of the run-length byte decoder: parser, run queue, output register.
// Depends on rlbd_pkg, rlbd_front, rlbd_queue, rlbd_back.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata[7:0] code_byte, s_tlast stream_last
//   m_*      out  m_tvalid/m_tready  m_tdata[7:0] pixel_value, [32:8] run_length,
//                                    m_tlast image_end
//   cfg_*    in   cfg_we             cfg_wdata pixel_total
//
// One code byte is taken per cycle while s_tready is high; its runs pass through the run
// queue and the output register. The final byte may yield two runs (pending run plus zero
// pad); the output register then presents them in turn. s_tready drops while the 4-entry
// run queue holds more than two runs. Reset is synchronous and needs no clearing pass.
`default_nettype none

module run_length_byte_decoder_top
  import rlbd_pkg::*;
#(
  parameter int PixelCountBits = PixelCountBitsDef
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [LenW-1:0] cfg_wdata,    // pixel_total
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,      // [7:0] code_byte
  input  wire logic            s_tlast,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [39:0]          m_tdata,      // [7:0] pixel_value, [32:8] run_length, zeros
  output logic                 m_tlast
);

  push_t push;
  logic  room;
  logic  rd_valid;
  run_t  rd_data;
  logic  pop;
  run_t  out_run;
  logic  take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  rlbd_front #(
    .PixelCountBits(PixelCountBits)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .take       (take),
    .code_byte  (s_tdata),
    .stream_last(s_tlast),
    .push       (push)
  );

  rlbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .rd_valid(rd_valid),
    .rd_data (rd_data),
    .pop     (pop)
  );

  rlbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_run  (out_run)
  );

  // Output packing
  assign m_tdata = {7'd0, out_run.length, out_run.value};
  assign m_tlast = out_run.last;

endmodule

`default_nettype wire
